/* design/sip_pkg.sv */
// ----------------------------------------------------------------------------
// sip_pkg
// Shared types, constants and the SipRound function of the SipHash-2-4 unit.
// ----------------------------------------------------------------------------
package sip_pkg;

   localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
   localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
   localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
   localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
   localparam logic [63:0] SIP_FIN_XOR = 64'h00000000000000ff;

   localparam logic CSR_KEY_LOW  = 1'b0;
   localparam logic CSR_KEY_HIGH = 1'b1;

   localparam logic [3:0] SIP_WORD_BYTES = 4'd8;

   typedef struct packed {
      logic [63:0] word;
      logic [7:0]  len;
      logic        start;
      logic        last;
      logic        full;
   } sip_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } sip_q_status_type;

   typedef struct packed {
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] c;
      logic [63:0] d;
   } sip_lanes_type;

   function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
      rotl64 = (x << r) | (x >> (64 - r));
   endfunction

   function automatic sip_lanes_type sip_round(input sip_lanes_type v);
      sip_lanes_type o;
      o = v;
      o.a = o.a + o.b;
      o.b = rotl64(o.b, 13) ^ o.a;
      o.a = rotl64(o.a, 32);
      o.c = o.c + o.d;
      o.d = rotl64(o.d, 16) ^ o.c;
      o.a = o.a + o.d;
      o.d = rotl64(o.d, 21) ^ o.a;
      o.c = o.c + o.b;
      o.b = rotl64(o.b, 17) ^ o.c;
      o.c = rotl64(o.c, 32);
      return o;
   endfunction

endpackage

/* design/sip_front.sv */
// ----------------------------------------------------------------------------
// sip_front
// Takes message beats, tracks length and message start, masks the tail word
// and pushes one command per beat into the queue.
// ----------------------------------------------------------------------------
module sip_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [63:0]               req_data_word,
   input  logic [3:0]                req_valid_bytes,
   input  logic                      req_last,
   input  sip_pkg::sip_q_status_type q_status,
   output logic                      q_push,
   output sip_pkg::sip_cmd_type      q_cmd
);
   import sip_pkg::*;

   logic        mid_ff, mid_in;
   logic [7:0]  len_ff, len_in;
   logic [3:0]  nbytes;
   logic [7:0]  len_sum;
   logic [63:0] masked;

   always_comb begin
      if (!req_last || req_valid_bytes > SIP_WORD_BYTES) begin
         nbytes = SIP_WORD_BYTES;
      end else begin
         nbytes = req_valid_bytes;
      end
      len_sum = (mid_ff ? len_ff : 8'd0) + {4'd0, nbytes};
      for (int i = 0; i < 8; i++) begin
         masked[8*i +: 8] = (4'(i) < nbytes) ? req_data_word[8*i +: 8] : 8'd0;
      end
   end

   assign req_stall = q_status.full;
   assign q_push    = req_valid && !q_status.full;

   always_comb begin
      q_cmd.start = !mid_ff;
      q_cmd.last  = req_last;
      q_cmd.full  = req_last && (nbytes == SIP_WORD_BYTES);
      q_cmd.len   = len_sum;
      if (!req_last || nbytes == SIP_WORD_BYTES) begin
         q_cmd.word = req_data_word;
      end else begin
         q_cmd.word = masked | {len_sum, 56'd0};
      end
   end

   always_comb begin
      mid_in = mid_ff;
      len_in = len_ff;
      if (q_push) begin
         mid_in = !req_last;
         len_in = req_last ? 8'd0 : len_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff <= 1'b0;
         len_ff <= 8'd0;
      end else begin
         mid_ff <= mid_in;
         len_ff <= len_in;
      end
   end

endmodule

/* design/sip_queue.sv */
// ----------------------------------------------------------------------------
// sip_queue
// Two-entry command queue between the front end and the round engine.
// ----------------------------------------------------------------------------
module sip_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  sip_pkg::sip_cmd_type      push_cmd,
   input  logic                      pop,
   output sip_pkg::sip_cmd_type      head_cmd,
   output sip_pkg::sip_q_status_type status
);
   import sip_pkg::*;

   sip_cmd_type entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign head_cmd     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* design/sip_core.sv */
// ----------------------------------------------------------------------------
// sip_core
// Round engine: one SipRound per cycle for compression and finalization, but a busy
// tag output stalls the last finalization round; holds the lanes and the tag output register.
// ----------------------------------------------------------------------------
module sip_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [63:0]          key_low,
   input  logic [63:0]          key_high,
   input  sip_pkg::sip_cmd_type head_cmd,
   input  logic                 q_empty,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [63:0]          rsp_tag
);
   import sip_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMP,
      ST_FIN
   } state_type;

   state_type     state_ff;
   logic [1:0]    cnt_ff;
   logic          last_ff;
   logic          tail_pend_ff;
   logic [7:0]    len_ff;
   logic [63:0]   m_ff;
   sip_lanes_type lanes_ff;
   logic          rsp_valid_ff;
   logic [63:0]   tag_ff;

   sip_lanes_type key_init, src, pre, rnd;
   logic [63:0]   msg;
   logic          out_free;

   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_tag   = tag_ff;

   always_comb begin
      key_init.a = SIP_C0 ^ key_low;
      key_init.b = SIP_C1 ^ key_high;
      key_init.c = SIP_C2 ^ key_low;
      key_init.d = SIP_C3 ^ key_high;
      src = (state_ff == ST_IDLE && head_cmd.start) ? key_init : lanes_ff;
      msg = (state_ff == ST_IDLE) ? head_cmd.word : m_ff;
      pre = src;
      if (state_ff == ST_IDLE || (state_ff == ST_COMP && cnt_ff == 2'd0)) begin
         pre.d = pre.d ^ msg;
      end
      if (state_ff == ST_FIN && cnt_ff == 2'd0) begin
         pre.c = pre.c ^ SIP_FIN_XOR;
      end
      rnd = sip_round(pre);
      if (state_ff == ST_COMP && cnt_ff == 2'd1) begin
         rnd.a = rnd.a ^ m_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 2'd0;
         last_ff      <= 1'b0;
         tail_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (q_pop) begin
                  lanes_ff     <= rnd;
                  m_ff         <= head_cmd.word;
                  len_ff       <= head_cmd.len;
                  last_ff      <= head_cmd.last;
                  tail_pend_ff <= head_cmd.last && head_cmd.full;
                  cnt_ff       <= 2'd1;
                  state_ff     <= ST_COMP;
               end
            end
            ST_COMP: begin
               lanes_ff <= rnd;
               if (cnt_ff == 2'd0) begin
                  cnt_ff <= 2'd1;
               end else begin
                  cnt_ff <= 2'd0;
                  if (tail_pend_ff) begin
                     m_ff         <= {len_ff, 56'd0};
                     tail_pend_ff <= 1'b0;
                  end else if (last_ff) begin
                     state_ff <= ST_FIN;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_FIN: begin
               if (cnt_ff != 2'd3) begin
                  lanes_ff <= rnd;
                  cnt_ff   <= cnt_ff + 2'd1;
               end else if (out_free) begin
                  lanes_ff     <= rnd;
                  tag_ff       <= rnd.a ^ rnd.b ^ rnd.c ^ rnd.d;
                  rsp_valid_ff <= 1'b1;
                  cnt_ff       <= 2'd0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_tail_only_on_last: assert property (@(posedge clock) disable iff (reset)
      tail_pend_ff |-> last_ff)
      else $error("pending length tail without final word");

   a_tag_issued: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && cnt_ff == 2'd3 && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finalization finished without issuing a tag");

   a_fin_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && cnt_ff == 2'd3 && !out_free) |=> (state_ff == ST_FIN && $stable(lanes_ff)))
      else $error("finalization advanced while output busy");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMP || state_ff == ST_FIN) |-> !q_pop)
      else $error("command popped while engine busy");
`endif

endmodule

/* design/siphash_2_4_mac_unit.sv */
// ----------------------------------------------------------------------------
// siphash_2_4_mac_unit
// Keyed SipHash-2-4 MAC over little-endian 64-bit message beats.
//
//   channel  dir  handshake           payload
//   req      in   req_valid/stall     data_word, valid_bytes, last
//   rsp      out  rsp_valid/stall     tag
//   csr      in   csr_valid/ready     index, data (key_low, key_high)
//
// One shared SipRound unit does one round per cycle while busy, unless a stalled tag holds it.
// Each beat is compressed; a final beat of 8 bytes also compresses a length word, then finalization runs.
// A two-entry command queue lets the input keep taking beats while rounds run, until it fills.
// Reset clears control state and both key halves; csr_ready is always high.
// A stalled tag holds the engine at its last finalization round.
// ----------------------------------------------------------------------------
module siphash_2_4_mac_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_valid_bytes,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_tag,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [63:0] csr_data
);
   import sip_pkg::*;

   logic             [63:0] key_low_ff;
   logic             [63:0] key_high_ff;
   logic                    q_push;
   logic                    q_pop;
   sip_cmd_type             push_cmd;
   sip_cmd_type             head_cmd;
   sip_q_status_type        q_status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= 64'd0;
         key_high_ff <= 64'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_KEY_LOW:  key_low_ff  <= csr_data;
            CSR_KEY_HIGH: key_high_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   sip_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_word   (req_data_word),
      .req_valid_bytes (req_valid_bytes),
      .req_last        (req_last),
      .q_status        (q_status),
      .q_push          (q_push),
      .q_cmd           (push_cmd)
   );

   sip_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   sip_core u_core (
      .clock     (clock),
      .reset     (reset),
      .key_low   (key_low_ff),
      .key_high  (key_high_ff),
      .head_cmd  (head_cmd),
      .q_empty   (q_status.empty),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_tag   (rsp_tag)
   );

endmodule
